// ===== design/lpd_pkg.sv =====
package lpd_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned MAX_FRAME_DEF    = 65536;

  // Fixed field widths of the streams
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DLEN_W  = 17;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_TUSER_W = 2;

  // Bit positions inside m_axis_tuser
  localparam int unsigned TUSER_PAYLOAD = 0;
  localparam int unsigned TUSER_LEN_ERR = 1;

  typedef struct packed {
    logic [DLEN_W-1:0] declared_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
    logic              length_error;
    logic              payload_valid;
  } lpd_res_t;

endpackage

// ===== design/length_prefix_deframer.sv =====
// Length-prefixed frame deframer.
// Slave stream s_axis carries the raw byte stream, one byte per transaction.
// Each frame opens with a little-endian length of HEADER_BYTES bytes that
// counts the header itself; the following length - HEADER_BYTES bytes are
// passed out as payload. Master stream m_axis returns exactly one
// transaction per input byte: tuser[0] marks payload bytes (tdata[7:0] is
// zero otherwise), tlast marks the byte that completes a frame (an empty
// frame completes on its last header byte), tuser[1] flags a header whose
// length is below HEADER_BYTES or above MAX_FRAME, and tdata[24:8] carries
// the declared length of the current frame.
// Results are registered; throughput is one byte per cycle while the receiver
// does not stall, set by the single register stage holding the parse state.
// A two-entry output (result register plus skid register) keeps
// s_axis_tready registered: one more byte is taken after the receiver
// stalls, then tready drops until the skid entry drains.
// Reset clears the parse state to header hunt and empties both entries.
module length_prefix_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_FRAME    = MAX_FRAME_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [7:0] data_byte
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // [7:0] payload_byte,
                                                 // [24:8] declared_length, [31:25] zero
  output logic                 m_axis_tlast_o,   // frame_end
  output logic [M_TUSER_W-1:0] m_axis_tuser_o    // [0] payload_valid, [1] length_error
);

  // Widths derived from the parameters
  localparam int unsigned LEN_W = 8 * HEADER_BYTES;
  localparam int unsigned HB_W  = (HEADER_BYTES > 1) ? 8 * (HEADER_BYTES - 1) : 8;
  localparam int unsigned CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int unsigned FT_W  = $clog2(longint'(MAX_FRAME) + 1);
  localparam int unsigned CMP_W = (LEN_W > 32) ? LEN_W : 32;
  localparam int unsigned MW    = (FT_W > DLEN_W) ? FT_W : DLEN_W;
  localparam int unsigned LAST_HDR = HEADER_BYTES - 1;

  // Parse state
  logic             in_payload_q, in_payload_d;
  logic [CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [HB_W-1:0]  hdr_bytes_q, hdr_bytes_d;
  logic [FT_W-1:0]  frame_total_q, frame_total_d;
  logic [FT_W-1:0]  byte_pos_q, byte_pos_d;

  // Output entries
  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  lpd_res_t out_q, out_d;
  lpd_res_t skid_q, skid_d;
  lpd_res_t res;

  logic             s_accept;
  logic [BYTE_W-1:0] in_byte;
  logic [FT_W-1:0]  pos_inc;
  logic [LEN_W-1:0] hdr_len;
  logic [CMP_W-1:0] len_cmp;
  logic             len_big;
  logic             len_small;
  logic [FT_W-1:0]  len_sat;
  logic [MW-1:0]    total_wide;
  logic [MW-1:0]    sat_wide;

  assign s_axis_tready_o = !skid_valid_q;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_byte         = s_axis_tdata_i[BYTE_W-1:0];

  // Header length assembled from the gathered bytes and the current one
  assign hdr_len    = LEN_W'(hdr_bytes_q) | (LEN_W'(in_byte) << (8 * LAST_HDR));
  assign len_cmp    = CMP_W'(hdr_len);
  assign len_big    = len_cmp > CMP_W'(MAX_FRAME);
  assign len_small  = len_cmp < CMP_W'(HEADER_BYTES);
  assign len_sat    = len_big ? FT_W'(MAX_FRAME) : FT_W'(hdr_len);
  assign pos_inc    = byte_pos_q + FT_W'(1);
  assign total_wide = MW'(frame_total_q);
  assign sat_wide   = MW'(len_sat);

  // Next parse state and result for the incoming byte
  always_comb begin
    in_payload_d  = in_payload_q;
    hdr_cnt_d     = hdr_cnt_q;
    hdr_bytes_d   = hdr_bytes_q;
    frame_total_d = frame_total_q;
    byte_pos_d    = byte_pos_q;
    res           = '0;

    if (in_payload_q) begin
      res.payload_byte    = in_byte;
      res.payload_valid   = 1'b1;
      res.declared_length = total_wide[DLEN_W-1:0];
      byte_pos_d          = pos_inc;
      if (pos_inc >= frame_total_q) begin
        // frame done: back to header hunt
        res.frame_end = 1'b1;
        in_payload_d  = 1'b0;
        hdr_cnt_d     = '0;
        hdr_bytes_d   = '0;
        frame_total_d = '0;
        byte_pos_d    = '0;
      end
    end else if (hdr_cnt_q != CNT_W'(LAST_HDR)) begin
      // gather one more header byte
      for (int unsigned i = 0; i < HB_W / 8; i++) begin
        if (hdr_cnt_q == CNT_W'(i)) begin
          hdr_bytes_d[8*i +: 8] = in_byte;
        end
      end
      hdr_cnt_d = hdr_cnt_q + CNT_W'(1);
    end else begin
      res.declared_length = sat_wide[DLEN_W-1:0];
      in_payload_d  = 1'b0;
      hdr_cnt_d     = '0;
      hdr_bytes_d   = '0;
      frame_total_d = '0;
      byte_pos_d    = '0;
      if (len_small || len_big) begin
        res.length_error = 1'b1;
      end else if (len_cmp == CMP_W'(HEADER_BYTES)) begin
        // empty frame ends on its last header byte
        res.frame_end = 1'b1;
      end else begin
        in_payload_d  = 1'b1;
        frame_total_d = FT_W'(hdr_len);
        byte_pos_d    = FT_W'(HEADER_BYTES);
      end
    end
  end

  // Result register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || m_axis_tready_i) begin
      // output slot free this cycle: drain skid first, else load new result
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = s_accept;
      end
    end else if (s_accept) begin
      // receiver stalled: park the new result
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q  <= 1'b0;
      hdr_cnt_q     <= '0;
      hdr_bytes_q   <= '0;
      frame_total_q <= '0;
      byte_pos_q    <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (s_accept) begin
        in_payload_q  <= in_payload_d;
        hdr_cnt_q     <= hdr_cnt_d;
        hdr_bytes_q   <= hdr_bytes_d;
        frame_total_q <= frame_total_d;
        byte_pos_q    <= byte_pos_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload entries hold without reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'({out_q.declared_length, out_q.payload_byte});
  assign m_axis_tlast_o  = out_q.frame_end;
  assign m_axis_tuser_o  = {out_q.length_error, out_q.payload_valid};

endmodule

// ===== design/lpd_checker.sv =====
module lpd_checker
  import lpd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 m_axis_tlast_o,
  input logic [M_TUSER_W-1:0] m_axis_tuser_o
);

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("stalled output changed");

  // Input backpressure only while a result is pending
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("tready low with empty output");

  // A bad header never ends a frame nor carries payload
  a_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[TUSER_LEN_ERR] |->
      !m_axis_tlast_o && !m_axis_tuser_o[TUSER_PAYLOAD])
    else $error("length error with frame end or payload");

  // Non-payload bytes carry a zero data byte
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[TUSER_PAYLOAD] |->
      m_axis_tdata_o[BYTE_W-1:0] == '0)
    else $error("header byte with nonzero data");

  // Padding bits above declared_length stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[M_TDATA_W-1:BYTE_W+DLEN_W] == '0)
    else $error("tdata padding not zero");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
